// ===== design/deq_pkg.sv =====
// Shared types and constants for the double-ended queue.
`default_nettype none
package deq_pkg;

    typedef logic signed [31:0] word_t;

    localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [1:0] OP_PUSH_BACK  = 2'd1;
    localparam logic [1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [1:0] OP_POP_BACK   = 2'd3;

    localparam word_t EMPTY_WORD = -32'sd1;

    typedef struct packed {
        logic add_front;
        logic add_back;
        logic take_front;
        logic take_back;
    } deq_cmd_t;

endpackage
`default_nettype wire

// ===== design/deq_cell.sv =====
// One storage cell of the queue chain: a word, a full flag and the neighbor moves.
`default_nettype none
module deq_cell (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  deq_pkg::deq_cmd_t   cmd,
    input  deq_pkg::word_t      push_word,
    input  deq_pkg::word_t      left_word,
    input  wire                 left_full,
    input  deq_pkg::word_t      right_word,
    input  wire                 right_full,
    output deq_pkg::word_t      word,
    output logic                full,
    output deq_pkg::word_t      back_word
);
    import deq_pkg::*;

    word_t word_reg;
    word_t word_next;
    logic  full_reg;
    logic  full_next;

    always_comb begin
        word_next = word_reg;
        full_next = full_reg;
        if (cmd.add_front) begin
            word_next = left_word;
            full_next = left_full;
        end else if (cmd.add_back) begin
            if (!full_reg && left_full) begin
                word_next = push_word;
                full_next = 1'b1;
            end
        end else if (cmd.take_front) begin
            word_next = right_word;
            full_next = right_full;
        end else if (cmd.take_back) begin
            if (full_reg && !right_full) begin
                full_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
        end else begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word      = word_reg;
    assign full      = full_reg;
    // The last occupied cell drives its word onto the back bus.
    assign back_word = (full_reg && !right_full) ? word_reg : '0;

endmodule
`default_nettype wire

// ===== design/double_ended_queue.sv =====
// Top level of the double-ended queue built as a chain of storage cells.
`default_nettype none
// The queue holds up to DEPTH signed 32-bit words in a row of cells, with the
// front word always in the first cell. A push at the front shifts the whole row
// one cell toward the back, a pop at the front shifts it toward the front, and
// the back end is the last cell whose neighbor is empty. The cells update at
// the edge the word is accepted; then, in the report state, the front word,
// the back word (gathered from the cells) and the occupancy are loaded into the
// output register. A new word is accepted while an earlier result still waits
// in the output register, but the report cycle waits until that register is
// free. Pushing into a full queue sets overflow and changes nothing; popping
// an empty queue sets underflow and changes nothing. Front and back read as all
// ones when the queue is empty.
module double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire  [1:0]          s_func,
    input  deq_pkg::word_t      s_value,
    output logic                m_valid,
    input  wire                 m_ready,
    output deq_pkg::word_t      m_popped_value,
    output logic                m_underflow,
    output logic                m_overflow,
    output deq_pkg::word_t      m_front_value,
    output deq_pkg::word_t      m_back_value,
    output logic [4:0]          m_occupancy
);
    import deq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_REPORT = 1'b1;

    logic          state_reg;
    logic          state_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    word_t         popped_reg;
    logic          under_reg;
    logic          over_reg;

    logic          m_valid_reg;
    word_t         m_popped_reg;
    logic          m_under_reg;
    logic          m_over_reg;
    word_t         m_front_reg;
    word_t         m_back_reg;
    logic [4:0]    m_occ_reg;

    word_t         cell_word [DEPTH];
    logic          cell_full [DEPTH];
    word_t         cell_back [DEPTH];
    word_t         back_bus;

    logic          accept;
    logic          is_full;
    logic          is_empty;
    logic          is_push;
    logic          op_ok;
    logic          load_out;
    deq_cmd_t      cmd;

    assign accept   = s_valid && s_ready;
    assign is_full  = cell_full[DEPTH-1];
    assign is_empty = !cell_full[0];
    assign is_push  = (s_func == OP_PUSH_FRONT) || (s_func == OP_PUSH_BACK);
    assign op_ok    = is_push ? !is_full : !is_empty;
    assign load_out = (state_reg == ST_REPORT) && (!m_valid_reg || m_ready);

    always_comb begin
        cmd = '0;
        if (accept && op_ok) begin
            case (s_func)
                OP_PUSH_FRONT: cmd.add_front  = 1'b1;
                OP_PUSH_BACK:  cmd.add_back   = 1'b1;
                OP_POP_FRONT:  cmd.take_front = 1'b1;
                OP_POP_BACK:   cmd.take_back  = 1'b1;
                default:       cmd = '0;
            endcase
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        word_t left_word;
        logic  left_full;
        word_t right_word;
        logic  right_full;

        if (i == 0) begin : g_first
            assign left_word = s_value;
            assign left_full = 1'b1;
        end else begin : g_mid_left
            assign left_word = cell_word[i-1];
            assign left_full = cell_full[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_word = '0;
            assign right_full = 1'b0;
        end else begin : g_mid_right
            assign right_word = cell_word[i+1];
            assign right_full = cell_full[i+1];
        end

        deq_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cmd),
            .push_word  (s_value),
            .left_word  (left_word),
            .left_full  (left_full),
            .right_word (right_word),
            .right_full (right_full),
            .word       (cell_word[i]),
            .full       (cell_full[i]),
            .back_word  (cell_back[i])
        );
    end

    always_comb begin
        back_bus = '0;
        for (int i = 0; i < DEPTH; i++) begin
            back_bus = back_bus | cell_back[i];
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.add_front || cmd.add_back) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.take_front || cmd.take_back) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            under_reg <= !is_push && is_empty;
            over_reg  <= is_push && is_full;
            if (cmd.take_front) begin
                popped_reg <= cell_word[0];
            end else if (cmd.take_back) begin
                popped_reg <= back_bus;
            end else begin
                popped_reg <= '0;
            end
        end
        if (load_out) begin
            m_popped_reg <= popped_reg;
            m_under_reg  <= under_reg;
            m_over_reg   <= over_reg;
            m_front_reg  <= is_empty ? EMPTY_WORD : cell_word[0];
            m_back_reg   <= is_empty ? EMPTY_WORD : back_bus;
            m_occ_reg    <= 5'(count_reg);
        end
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_popped_value = m_popped_reg;
    assign m_underflow    = m_under_reg;
    assign m_overflow     = m_over_reg;
    assign m_front_value  = m_front_reg;
    assign m_back_value   = m_back_reg;
    assign m_occupancy    = m_occ_reg;

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the bounded double-ended queue of signed words.
`default_nettype none
module tb;
    import deq_pkg::*;

    localparam int QUEUE_DEPTH = 16;

    typedef struct {
        word_t      popped_value;
        logic       underflow;
        logic       overflow;
        word_t      front_value;
        word_t      back_value;
        logic [4:0] occupancy;
    } deque_outcome_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_func = OP_PUSH_FRONT;
    word_t      s_value = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    word_t      m_popped_value;
    logic       m_underflow;
    logic       m_overflow;
    word_t      m_front_value;
    word_t      m_back_value;
    logic [4:0] m_occupancy;

    word_t          ring_words [QUEUE_DEPTH];
    int             ring_head = 0;
    int             ring_count = 0;
    deque_outcome_t pending_outcomes [$];
    int             error_count = 0;
    bit             idle_on = 1'b1;

    double_ended_queue #(.DEPTH(QUEUE_DEPTH)) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_popped_value (m_popped_value),
        .m_underflow    (m_underflow),
        .m_overflow     (m_overflow),
        .m_front_value  (m_front_value),
        .m_back_value   (m_back_value),
        .m_occupancy    (m_occupancy)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("** double_ended_queue: FAILED **");
        $finish;
    end

    function automatic deque_outcome_t apply_deque_op(logic [1:0] func, word_t value);
        deque_outcome_t res;
        res.popped_value = '0;
        res.underflow    = 1'b0;
        res.overflow     = 1'b0;
        res.front_value  = EMPTY_WORD;
        res.back_value   = EMPTY_WORD;
        case (func)
            OP_PUSH_FRONT: begin
                if (ring_count >= QUEUE_DEPTH) begin
                    res.overflow = 1'b1;
                end else begin
                    ring_head = (ring_head + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
                    ring_words[ring_head] = value;
                    ring_count++;
                end
            end
            OP_PUSH_BACK: begin
                if (ring_count >= QUEUE_DEPTH) begin
                    res.overflow = 1'b1;
                end else begin
                    ring_words[(ring_head + ring_count) % QUEUE_DEPTH] = value;
                    ring_count++;
                end
            end
            OP_POP_FRONT: begin
                if (ring_count == 0) begin
                    res.underflow = 1'b1;
                end else begin
                    res.popped_value = ring_words[ring_head];
                    ring_head = (ring_head + 1) % QUEUE_DEPTH;
                    ring_count--;
                end
            end
            default: begin
                if (ring_count == 0) begin
                    res.underflow = 1'b1;
                end else begin
                    res.popped_value = ring_words[(ring_head + ring_count - 1) % QUEUE_DEPTH];
                    ring_count--;
                end
            end
        endcase
        if (ring_count != 0) begin
            res.front_value = ring_words[ring_head];
            res.back_value  = ring_words[(ring_head + ring_count - 1) % QUEUE_DEPTH];
        end
        res.occupancy = ring_count[4:0];
        return res;
    endfunction

    task automatic send_word(input logic [1:0] func, input word_t value);
        if (idle_on) begin
            while ($urandom_range(0, 99) < 25) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_func  <= func;
        s_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_outcomes.insert(pending_outcomes.size(), apply_deque_op(func, value));
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected %h, actual %h", name, exp_val, act_val);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn || !idle_on) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= 25);
        end
    end

    always @(posedge aclk) begin
        deque_outcome_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (pending_outcomes.size() == 0) begin
                $error("result word with no expectation waiting");
                error_count++;
            end else begin
                exp_res = pending_outcomes[0];
                pending_outcomes.delete(0);
                check_field("popped_value", exp_res.popped_value, m_popped_value);
                check_field("underflow", exp_res.underflow, m_underflow);
                check_field("overflow", exp_res.overflow, m_overflow);
                check_field("front_value", exp_res.front_value, m_front_value);
                check_field("back_value", exp_res.back_value, m_back_value);
                check_field("occupancy", exp_res.occupancy, m_occupancy);
            end
        end
    end

    function automatic word_t pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3: return EMPTY_WORD;
            default: return $urandom();
        endcase
    endfunction

    task automatic test_empty_pops();
        send_word(OP_POP_FRONT, 32'h1234_5678);
        send_word(OP_POP_BACK, EMPTY_WORD);
    endtask

    task automatic test_fill_and_overflow();
        word_t extremes [8];
        extremes = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                     32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0001};
        foreach (extremes[i]) send_word(OP_PUSH_BACK, extremes[i]);
        foreach (extremes[i]) send_word(OP_PUSH_FRONT, ~extremes[i]);
        send_word(OP_PUSH_FRONT, 32'h0BAD_F00D);
        send_word(OP_PUSH_BACK, 32'hDEAD_BEEF);
    endtask

    task automatic test_pops_from_both_ends();
        send_word(OP_POP_FRONT, '0);
        send_word(OP_POP_BACK, '0);
        send_word(OP_POP_FRONT, EMPTY_WORD);
        send_word(OP_POP_BACK, EMPTY_WORD);
    endtask

    // Bursts lean toward pushes or pops, or mix both evenly, so that the queue keeps reaching
    // both the full and the empty state, with the ring head wrapping around.
    task automatic test_random_traffic(input int word_total);
        int         remaining;
        int         burst_len;
        int         push_pct;
        logic [1:0] func;
        remaining = word_total;
        while (remaining > 0) begin
            burst_len = $urandom_range(8, 40);
            case ($urandom_range(0, 2))
                0: push_pct = 80;
                1: push_pct = 20;
                default: push_pct = 50;
            endcase
            while (burst_len > 0 && remaining > 0) begin
                if ($urandom_range(0, 99) < push_pct) begin
                    func = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
                end else begin
                    func = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
                end
                send_word(func, pick_value());
                burst_len--;
                remaining--;
            end
        end
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        test_random_traffic(300);
        idle_on = 1'b1;
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_pops();
        test_fill_and_overflow();
        test_pops_from_both_ends();
        test_random_traffic(800);
        test_back_to_back();
        test_random_traffic(726);
        wait_for_results();
        if (error_count == 0) begin
            $display("** double_ended_queue: PASSED **");
        end else begin
            $display("** double_ended_queue: FAILED **");
        end
        $finish;
    end

endmodule
`default_nettype wire
